FILE: rtl/mcs_pkg.sv
// Package for the control surface state core: codes, field widths and the
// command, status and configuration structs shared by its modules.
// No dependencies.
package mcs_pkg;

   // Default strip count
   localparam int CHANNELS_DEFAULT = 8;

   // Port widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;
   localparam int USER_W     = 2;
   localparam int ADDR_W     = 4;
   localparam int CSR_DATA_W = 32;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int DATA_W  = 7;
   localparam int CHAN_W  = 3;
   localparam int FADER_W = 14;
   localparam int COUNT_W = 4;

   // Input operations
   localparam logic [1:0] OP_MIDI = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_REPORT  = 2'd0;
   localparam logic [1:0] KIND_LED     = 2'd1;
   localparam logic [1:0] KIND_DISPLAY = 2'd2;
   localparam logic [1:0] KIND_ECHO    = 2'd3;

   // MIDI message types (upper nibble of the status byte)
   localparam logic [3:0] TYPE_NOTE_OFF   = 4'h8;
   localparam logic [3:0] TYPE_NOTE_ON    = 4'h9;
   localparam logic [3:0] TYPE_CONTROL    = 4'hB;
   localparam logic [3:0] TYPE_PITCH_BEND = 4'hE;

   // Outgoing status and LED level
   localparam logic [7:0] STATUS_NOTE_ON = 8'h90;
   localparam logic [6:0] LED_FULL       = 7'h7F;
   localparam logic [6:0] LEVEL_MAX      = 7'd127;

   // Rows of eight in the note / controller number space (value / 8)
   localparam logic [3:0] ROW_LED_OFF = 4'd0;
   localparam logic [3:0] ROW_BANK1   = 4'd1;
   localparam logic [3:0] ROW_BANK2   = 4'd2;
   localparam logic [3:0] ROW_BANK3   = 4'd3;
   localparam logic [3:0] ROW_DIAL    = 4'd2;
   localparam logic [3:0] ROW_TOUCH   = 4'd13;

   // Register indexes
   localparam logic [1:0] REG_ENCODER  = 2'd0;
   localparam logic [1:0] REG_LED_EN   = 2'd1;
   localparam logic [1:0] REG_DISP_EN  = 2'd2;
   localparam logic [1:0] REG_DEBOUNCE = 2'd3;

   typedef struct packed {
      logic                 encoder_relative;
      logic                 led_feedback_enable;
      logic                 display_feedback_enable;
      logic [COUNT_W-1:0]   debounce_ticks;
   } cfg_type;

   typedef struct packed {
      logic load;   // capture the input transfer
      logic exec;   // apply a message or read
      logic step;   // process one channel of a tick walk
   } cmd_type;

   typedef struct packed {
      logic req_tick;   // offered item is a tick
      logic emit;       // executed item gives a result
      logic step_emit;  // current walk channel expires
      logic walk_end;   // current walk channel is the last one
   } status_type;

endpackage

FILE: rtl/mcs_csr.sv
// Configuration register file of the control surface state core.
// APB-style write and read port; depends on mcs_pkg.
module mcs_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mcs_pkg::ADDR_W-1:0]      csr_paddr,
   input  logic [mcs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [mcs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output mcs_pkg::cfg_type                cfg
);

   mcs_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            mcs_pkg::REG_ENCODER:  cfg_in.encoder_relative        = csr_pwdata[0];
            mcs_pkg::REG_LED_EN:   cfg_in.led_feedback_enable     = csr_pwdata[0];
            mcs_pkg::REG_DISP_EN:  cfg_in.display_feedback_enable = csr_pwdata[0];
            mcs_pkg::REG_DEBOUNCE: cfg_in.debounce_ticks =
                                      csr_pwdata[mcs_pkg::COUNT_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.encoder_relative        <= 1'b1;
         cfg_ff.led_feedback_enable     <= 1'b1;
         cfg_ff.display_feedback_enable <= 1'b1;
         cfg_ff.debounce_ticks          <= mcs_pkg::COUNT_W'(2);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         mcs_pkg::REG_ENCODER:  csr_prdata[0] = cfg_ff.encoder_relative;
         mcs_pkg::REG_LED_EN:   csr_prdata[0] = cfg_ff.led_feedback_enable;
         mcs_pkg::REG_DISP_EN:  csr_prdata[0] = cfg_ff.display_feedback_enable;
         mcs_pkg::REG_DEBOUNCE: csr_prdata[mcs_pkg::COUNT_W-1:0] = cfg_ff.debounce_ticks;
         default:               csr_prdata = '0;
      endcase
   end

endmodule

FILE: rtl/mcs_ctrl.sv
// Controller of the control surface state core: sequences capture, execute,
// the per-channel tick walk and the result hold. Depends on mcs_pkg.
module mcs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output mcs_pkg::cmd_type     cmd,
   input  mcs_pkg::status_type  st
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_WALK = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       resume_ff, resume_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_HOLD);

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      resume_in = resume_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = st.req_tick ? ST_WALK : ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec  = 1'b1;
            resume_in = 1'b0;
            state_in  = st.emit ? ST_HOLD : ST_IDLE;
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (st.step_emit) begin
               resume_in = ~st.walk_end;
               state_in  = ST_HOLD;
            end else begin
               state_in = st.walk_end ? ST_IDLE : ST_WALK;
            end
         end
         ST_HOLD: begin
            if (rsp_tready) begin
               state_in = resume_ff ? ST_WALK : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         resume_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         resume_ff <= resume_in;
      end
   end

endmodule

FILE: rtl/mcs_datapath.sv
// Datapath of the control surface state core: input capture, per-strip
// state, message decode, dial arithmetic and the result register.
// Depends on mcs_pkg.
module mcs_datapath #(
   parameter int CHANNELS = mcs_pkg::CHANNELS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mcs_pkg::cfg_type                 cfg,
   input  mcs_pkg::cmd_type                 cmd,
   output mcs_pkg::status_type              st,
   input  logic [mcs_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [mcs_pkg::USER_W-1:0]       req_tuser,
   output logic [mcs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [mcs_pkg::USER_W-1:0]       rsp_tuser,
   output logic                             rsp_tlast
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [3:0]       CH_LIMIT = 4'(CHANNELS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

   // Captured input
   logic [1:0]                  op_ff;
   logic [mcs_pkg::BYTE_W-1:0]  sb_ff;
   logic [mcs_pkg::DATA_W-1:0]  d1_ff, d2_ff;
   logic [mcs_pkg::CHAN_W-1:0]  rc_ff;

   // Strip state
   logic [mcs_pkg::FADER_W-1:0] fader_ff   [CHANNELS];
   logic [mcs_pkg::COUNT_W-1:0] count_ff   [CHANNELS];
   logic [mcs_pkg::DATA_W-1:0]  dial_ff    [CHANNELS];
   logic [CHANNELS-1:0]         seen_ff, touch_ff, bank1_ff, bank2_ff, bank3_ff;
   logic [IDX_W-1:0]            widx_ff;

   // Result register
   logic [1:0]                  okind_ff;
   logic [mcs_pkg::BYTE_W-1:0]  ostatus_ff;
   logic [mcs_pkg::DATA_W-1:0]  od1_ff, od2_ff;
   logic [mcs_pkg::CHAN_W-1:0]  och_ff;
   logic                        ook_ff, olast_ff;

   // Decode
   logic [3:0]                  mtype, row;
   logic [2:0]                  col;
   logic [IDX_W-1:0]            idx, oidx;
   logic                        col_ok, is_msg, is_pb, is_cc, is_note, pressed;
   logic                        is_touch, is_ledoff, hit1, hit2, hit3, bank_hit;
   logic                        bank_new, led_emit, disp_emit, dial_chg;
   logic [mcs_pkg::DATA_W-1:0]  dial_old, dial_new;
   logic [mcs_pkg::DATA_W:0]    dial_up;
   logic [mcs_pkg::DATA_W-1:0]  dial_dn, step_mag;
   logic [mcs_pkg::COUNT_W-1:0] arm_val;
   logic [CHANNELS-1:0]         expire, above;
   logic                        last_echo;

   assign mtype   = sb_ff[7:4];
   assign row     = d1_ff[6:3];
   assign col     = d1_ff[2:0];
   assign idx     = col[IDX_W-1:0];
   assign col_ok  = ({1'b0, col} < CH_LIMIT);
   assign is_msg  = (op_ff == mcs_pkg::OP_MIDI);
   assign is_pb   = is_msg && (mtype == mcs_pkg::TYPE_PITCH_BEND) && (sb_ff[3:0] < CH_LIMIT);
   assign is_cc   = is_msg && (mtype == mcs_pkg::TYPE_CONTROL)
                    && (row == mcs_pkg::ROW_DIAL) && col_ok;
   assign is_note = is_msg && ((mtype == mcs_pkg::TYPE_NOTE_ON)
                    || (mtype == mcs_pkg::TYPE_NOTE_OFF));
   assign pressed = (mtype == mcs_pkg::TYPE_NOTE_ON) && (d2_ff != '0);

   assign is_touch  = (row == mcs_pkg::ROW_TOUCH) && col_ok;
   assign is_ledoff = (row == mcs_pkg::ROW_LED_OFF) && col_ok;
   assign hit1      = (row == mcs_pkg::ROW_BANK1) && col_ok;
   assign hit2      = (row == mcs_pkg::ROW_BANK2) && col_ok;
   assign hit3      = (row == mcs_pkg::ROW_BANK3) && col_ok;
   assign bank_hit  = hit1 | hit2 | hit3;
   assign bank_new  = hit1 ? ~bank1_ff[idx] : hit2 ? ~bank2_ff[idx] : ~bank3_ff[idx];
   assign led_emit  = is_note && !is_touch && pressed && (is_ledoff || bank_hit)
                      && cfg.led_feedback_enable;

   // Dial update: relative delta with clamping, or absolute
   assign dial_old = dial_ff[idx];
   assign step_mag = {1'b0, d2_ff[5:0]};
   assign dial_up  = {1'b0, dial_old} + {1'b0, step_mag};
   assign dial_dn  = (step_mag > dial_old) ? '0 : (dial_old - step_mag);
   always_comb begin
      if (!cfg.encoder_relative) begin
         dial_new = d2_ff;
      end else if (!d2_ff[6]) begin
         dial_new = dial_up[mcs_pkg::DATA_W] ? mcs_pkg::LEVEL_MAX
                                             : dial_up[mcs_pkg::DATA_W-1:0];
      end else begin
         dial_new = dial_dn;
      end
   end
   assign dial_chg  = (dial_new != dial_old);
   assign disp_emit = is_cc && dial_chg && cfg.display_feedback_enable;

   assign arm_val = (cfg.debounce_ticks == '0) ? mcs_pkg::COUNT_W'(1) : cfg.debounce_ticks;

   // Tick walk: which counters expire, and is any left above the current one
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         expire[i] = (count_ff[i] == mcs_pkg::COUNT_W'(1));
         above[i]  = (IDX_W'(i) > widx_ff);
      end
   end
   assign last_echo = ~|(expire & above);

   assign st.req_tick  = (req_tuser == mcs_pkg::OP_TICK);
   assign st.emit      = disp_emit || led_emit || (op_ff == mcs_pkg::OP_READ);
   assign st.step_emit = expire[widx_ff];
   assign st.walk_end  = (widx_ff == IDX_LAST);

   // Capture the input transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_tuser;
         sb_ff <= req_tdata[7:0];
         d1_ff <= req_tdata[14:8];
         d2_ff <= req_tdata[21:15];
         rc_ff <= req_tdata[24:22];
      end
   end

   // Walk index
   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         widx_ff <= '0;
      end else if (cmd.step && !st.walk_end) begin
         widx_ff <= widx_ff + IDX_W'(1);
      end
   end

   // Strip state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            fader_ff[i] <= '0;
            count_ff[i] <= '0;
            dial_ff[i]  <= '0;
         end
         seen_ff  <= '0;
         touch_ff <= '0;
         bank1_ff <= '0;
         bank2_ff <= '0;
         bank3_ff <= '0;
      end else if (cmd.exec) begin
         if (is_pb) begin
            fader_ff[sb_ff[IDX_W-1:0]] <= {d2_ff, d1_ff};
            seen_ff[sb_ff[IDX_W-1:0]]  <= 1'b1;
            count_ff[sb_ff[IDX_W-1:0]] <= arm_val;
         end
         if (is_cc) begin
            dial_ff[idx] <= dial_new;
         end
         if (is_note && is_touch) begin
            touch_ff[idx] <= pressed;
         end
         if (is_note && !is_touch && pressed) begin
            if (hit1) bank1_ff[idx] <= bank_new;
            if (hit2) bank2_ff[idx] <= bank_new;
            if (hit3) bank3_ff[idx] <= bank_new;
         end
      end else if (cmd.step) begin
         if (count_ff[widx_ff] != '0) begin
            count_ff[widx_ff] <= count_ff[widx_ff] - mcs_pkg::COUNT_W'(1);
         end
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.exec && st.emit) begin
         olast_ff <= 1'b1;
         if (op_ff == mcs_pkg::OP_READ) begin
            okind_ff   <= mcs_pkg::KIND_REPORT;
            ostatus_ff <= '0;
            od1_ff     <= '0;
            od2_ff     <= '0;
            och_ff     <= rc_ff;
            ook_ff     <= ({1'b0, rc_ff} < CH_LIMIT);
         end else if (disp_emit) begin
            okind_ff   <= mcs_pkg::KIND_DISPLAY;
            ostatus_ff <= '0;
            od1_ff     <= '0;
            od2_ff     <= '0;
            och_ff     <= col;
            ook_ff     <= 1'b1;
         end else begin
            okind_ff   <= mcs_pkg::KIND_LED;
            ostatus_ff <= mcs_pkg::STATUS_NOTE_ON;
            od1_ff     <= d1_ff;
            od2_ff     <= (!is_ledoff && bank_new) ? mcs_pkg::LED_FULL : '0;
            och_ff     <= col;
            ook_ff     <= 1'b1;
         end
      end else if (cmd.step && st.step_emit) begin
         olast_ff   <= last_echo;
         okind_ff   <= mcs_pkg::KIND_ECHO;
         ostatus_ff <= {mcs_pkg::TYPE_PITCH_BEND, 1'b0, mcs_pkg::CHAN_W'(widx_ff)};
         od1_ff     <= fader_ff[widx_ff][6:0];
         od2_ff     <= fader_ff[widx_ff][13:7];
         och_ff     <= mcs_pkg::CHAN_W'(widx_ff);
         ook_ff     <= 1'b1;
      end
   end

   // State fields read live: nothing changes while a result is held
   assign oidx = och_ff[IDX_W-1:0];
   always_comb begin
      rsp_tdata        = '0;
      rsp_tdata[7:0]   = ostatus_ff;
      rsp_tdata[14:8]  = od1_ff;
      rsp_tdata[21:15] = od2_ff;
      rsp_tdata[24:22] = och_ff;
      if (ook_ff) begin
         rsp_tdata[38:25] = fader_ff[oidx];
         rsp_tdata[45:39] = dial_ff[oidx];
         rsp_tdata[46]    = touch_ff[oidx];
         rsp_tdata[47]    = bank1_ff[oidx];
         rsp_tdata[48]    = bank2_ff[oidx];
         rsp_tdata[49]    = bank3_ff[oidx] & seen_ff[oidx];
      end
   end
   assign rsp_tuser = okind_ff;
   assign rsp_tlast = olast_ff;

endmodule

FILE: rtl/midi_control_surface_state_core.sv
// Channel        | Direction | Handshake                | Payload
// req_ (stream)  | in        | req_tvalid / req_tready  | tuser operation, tdata message
// rsp_ (stream)  | out       | rsp_tvalid / rsp_tready  | tuser kind, tdata, tlast
// csr_ (APB)     | in/out    | psel, penable, pready=1  | 4 registers at 4*i
//
// One item at a time. A message or read is captured and then executed, and
// each result it gives is held; a tick is captured and then walks the
// counters, one channel per cycle while no echo is held, holding each echo.
// The held result stalls the walk until rsp_tready. Reset is synchronous and
// clears all strip state at once; registers return to their defaults.
//
// Top level of the control surface state core; depends on mcs_pkg,
// mcs_csr, mcs_ctrl and mcs_datapath.
module midi_control_surface_state_core #(
   parameter int CHANNELS = mcs_pkg::CHANNELS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // status_byte[7:0], data_one[14:8], data_two[21:15], read_channel[24:22]
   input  logic [mcs_pkg::REQ_DATA_W-1:0]  req_tdata,
   // operation[1:0]
   input  logic [mcs_pkg::USER_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_status[7:0], out_data_one[14:8], out_data_two[21:15], channel[24:22],
   // fader_level[38:25], dial_level[45:39], touched[46], bank_one_on[47],
   // bank_two_on[48], bank_three_on[49]
   output logic [mcs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // result_kind[1:0]
   output logic [mcs_pkg::USER_W-1:0]      rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mcs_pkg::ADDR_W-1:0]      csr_paddr,
   input  logic [mcs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [mcs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   mcs_pkg::cfg_type    cfg;
   mcs_pkg::cmd_type    cmd;
   mcs_pkg::status_type st;

   mcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .st         (st)
   );

   mcs_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .st        (st),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

FILE: rtl/mcs_checker.sv
// Port-level checks for the control surface state core, bound to its top
// level. Depends on mcs_pkg.
module mcs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mcs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [mcs_pkg::USER_W-1:0]      rsp_tuser,
   input logic                            csr_pready
);

   // Held result keeps its payload until the transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // No new item while a result is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input open while a result is held");

   // Capture closes the input for the next cycle
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input still open after a transfer");

   // An echo carries pitch bend on its own channel
   a_echo_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == mcs_pkg::KIND_ECHO)
      |-> (rsp_tdata[7:4] == mcs_pkg::TYPE_PITCH_BEND) && (rsp_tdata[2:0] == rsp_tdata[24:22]))
      else $error("echo status does not match its channel");

   // Configuration port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("configuration port not ready");

endmodule

bind midi_control_surface_state_core mcs_checker u_mcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);
